// File: sv/cdf_pkg.sv
package cdf_pkg;

  typedef struct packed {
    logic signed [31:0] current_pos;
    logic signed [31:0] goal_pos;
  } cdf_in_t;

  typedef struct packed {
    logic signed [31:0] next_pos;
    logic signed [31:0] next_velocity;
  } cdf_out_t;

  localparam logic [1:0] RegSmoothTime = 2'd0;
  localparam logic [1:0] RegMaxSpeed   = 2'd1;
  localparam logic [1:0] RegDeltaTime  = 2'd2;

  localparam logic [30:0] MinSmoothRaw = 31'd7;
  localparam logic [15:0] CoefSq = 16'd31457;
  localparam logic [15:0] CoefCu = 16'd15401;
  localparam logic [34:0] PolyCap = 35'h2_0000_0000;

  localparam logic signed [63:0] SatMax = 64'sh0000_0000_7FFF_FFFF;
  localparam logic signed [63:0] SatMin = -64'sh0000_0000_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SatMax) r = 32'sh7FFF_FFFF;
    else if (v < SatMin) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// File: sv/critically_damped_follower.sv
// Critically damped follower: one smooth-damp spring step per transaction.
// Input channel in_valid_i/in_stall_o carries current_pos and goal_pos
// (signed Q16.16); output channel out_valid_o/out_stall_i returns next_pos
// and next_velocity (signed Q16.16, saturated).
// Configuration: cfg_we_i writes register cfg_idx_i (0 smooth_time,
// 1 max_speed, 2 delta_time) with cfg_data_i; other indexes are ignored.
// Work per item: two 64-step restoring divisions (omega, decay) run on
// one shared subtract unit, eleven passes of one shared 36x33 multiplier,
// and clamp, finish and done steps.
// A new item is accepted when the block is idle and its output register
// is empty; a stalled result holds in the output register and blocks
// further input until taken.
// Reset clears velocity to zero, loads the register defaults and empties
// the output register.
module critically_damped_follower (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [30:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cdf_pkg::cdf_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cdf_pkg::cdf_out_t out_data_o
);
  import cdf_pkg::*;

  typedef enum logic [4:0] {
    StIdle = 5'b00001,
    StDiv  = 5'b00010,
    StMul  = 5'b00100,
    StSeq  = 5'b01000,
    StDone = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [30:0] st_q, ms_q;
  logic [15:0] dt_q;
  logic signed [31:0] vel_q;
  logic out_valid_q;
  cdf_out_t out_q;

  logic signed [31:0] cur_q, goal_q;
  logic [4:0] step_q;
  logic [6:0] cnt_q;
  // divider
  logic [63:0] quo_q;
  logic [64:0] rem_q;
  logic [63:0] dvs_q;
  // multiplier operands / result
  logic signed [35:0] ma_q;
  logic signed [32:0] mb_q;
  logic signed [68:0] prod;
  logic signed [68:0] pr_q;

  logic [34:0] omega_q, x_q, x2_q, x3_q, decay_q;
  logic [46:0] lim_q;
  logic signed [31:0] err_q, tgt_q, t7_q, vn_q;
  logic [63:0] d_q;

  logic [30:0] st_eff;
  logic in_acc;
  logic signed [63:0] fl;
  logic [64:0] rem_sh;
  logic signed [31:0] pos_fin;

  assign st_eff = (st_q < MinSmoothRaw) ? MinSmoothRaw : st_q;
  assign in_stall_o = (state_q != StIdle) || out_valid_q;
  assign in_acc = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;
  assign prod = ma_q * mb_q;
  assign fl = 64'(pr_q >>> 16);
  assign rem_sh = {rem_q[63:0], quo_q[63]};
  assign pos_fin = sat32(64'(tgt_q) + 64'(sat32(fl)));

  // step codes
  localparam logic [4:0] SOmega = 5'd0, SX = 5'd1, SX2 = 5'd2, SX3 = 5'd3,
    SPolyA = 5'd4, SPolyB = 5'd5, SDecay = 5'd6, SLim = 5'd7, SErr = 5'd8,
    SOmErr = 5'd9, SDt = 5'd10, SOmT7 = 5'd11, SVnDec = 5'd12,
    SPosDec = 5'd13, SFin = 5'd14;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (in_acc) state_d = StDiv;
      StDiv:  if (cnt_q == 7'd63) state_d = StSeq;
      StMul:  state_d = StSeq;
      StSeq: begin
        unique case (step_q) inside
          SPolyB:     state_d = StDiv;
          SLim, SErr: state_d = StSeq;
          SFin:       state_d = StDone;
          default:    state_d = StMul;
        endcase
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      st_q <= 31'd65536;
      ms_q <= 31'h7FFF_FFFF;
      dt_q <= 16'd1092;
      vel_q <= '0;
      out_valid_q <= 1'b0;
      step_q <= SOmega;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegSmoothTime: st_q <= cfg_data_i;
          RegMaxSpeed:   ms_q <= cfg_data_i;
          RegDeltaTime:  dt_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      if (in_acc) begin
        step_q <= SOmega;
        cnt_q <= '0;
      end
      if (state_q == StDiv) cnt_q <= cnt_q + 7'd1;
      if (state_q == StSeq && step_q != SFin) begin
        step_q <= step_q + 5'd1;
        cnt_q <= '0;
      end
      if (state_q == StSeq && step_q == SFin) out_valid_q <= 1'b1;
      if (state_q == StDone) vel_q <= out_q.next_velocity;
    end
  end

  // Datapath: StSeq consumes the result of the previous unit op for
  // step_q and launches the next op, if any (divide -> StDiv, multiply -> StMul).
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cur_q <= in_data_i.current_pos;
      goal_q <= in_data_i.goal_pos;
      quo_q <= 64'h2_0000_0000;
      rem_q <= '0;
      dvs_q <= {33'd0, st_eff};
    end
    if (state_q == StDiv) begin
      if (rem_sh >= {1'b0, dvs_q}) begin
        rem_q <= rem_sh - {1'b0, dvs_q};
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[62:0], 1'b0};
      end
    end
    if (state_q == StMul) pr_q <= prod;
    if (state_q == StSeq) begin
      case (step_q)
        SOmega: begin
          omega_q <= quo_q[34:0];
          ma_q <= 36'(quo_q[34:0]);
          mb_q <= 33'(dt_q);
        end
        SX: begin
          x_q <= 35'(pr_q[68:16]);
          ma_q <= 36'(pr_q[50:16]);
          mb_q <= 33'(pr_q[47:16]);
        end
        SX2: begin
          x2_q <= ((pr_q >>> 16) > 69'(PolyCap)) ? PolyCap : 35'(pr_q[68:16]);
          ma_q <= ((pr_q >>> 16) > 69'(PolyCap)) ? 36'(PolyCap) : 36'(pr_q[50:16]);
          mb_q <= 33'(x_q[31:0]);
        end
        SX3: begin
          x3_q <= ((pr_q >>> 16) > 69'(PolyCap)) ? PolyCap : 35'(pr_q[68:16]);
          ma_q <= 36'(x2_q);
          mb_q <= 33'(CoefSq);
        end
        SPolyA: begin
          d_q <= 64'd65536 + 64'(x_q) + 64'(pr_q[68:16]);
          ma_q <= 36'(x3_q);
          mb_q <= 33'(CoefCu);
        end
        SPolyB: begin
          quo_q <= 64'h1_0000_0000;
          rem_q <= '0;
          dvs_q <= d_q + 64'(pr_q[68:16]);
        end
        SDecay: begin
          decay_q <= quo_q[34:0];
          ma_q <= 36'(ms_q);
          mb_q <= 33'(st_eff);
        end
        SLim: begin
          lim_q <= 47'(pr_q[68:16]);
          err_q <= sat32(64'(cur_q) - 64'(goal_q));
        end
        SErr: begin
          if (64'(err_q) > $signed({17'd0, lim_q}))
            err_q <= 32'(lim_q);
          else if (64'(err_q) < -$signed({17'd0, lim_q}))
            err_q <= 32'(-$signed({17'd0, lim_q}));
          ma_q <= 36'(omega_q);
          mb_q <= '0;
        end
        SOmErr: begin
          tgt_q <= sat32(64'(cur_q) - 64'(err_q));
          ma_q <= 36'(omega_q);
          mb_q <= 33'(err_q);
        end
        SDt: begin
          t7_q <= sat32(64'(vel_q) + 64'(sat32(fl)));
          ma_q <= 36'(sat32(64'(vel_q) + 64'(sat32(fl))));
          mb_q <= 33'(dt_q);
        end
        SOmT7: begin
          t7_q <= sat32(fl);
          ma_q <= 36'(omega_q);
          mb_q <= 33'(sat32(fl));
        end
        SVnDec: begin
          ma_q <= 36'(sat32(64'(vel_q) - 64'(sat32(fl))));
          mb_q <= 33'(decay_q);
        end
        SPosDec: begin
          vn_q <= sat32(fl);
          ma_q <= 36'(sat32(64'(err_q) + 64'(t7_q)));
          mb_q <= 33'(decay_q);
        end
        SFin: begin
          if (((64'(goal_q) - 64'(cur_q)) > 0) == (pos_fin > goal_q)) begin
            out_q.next_pos <= goal_q;
            out_q.next_velocity <= '0;
            vn_q <= '0;
          end else begin
            out_q.next_pos <= pos_fin;
            out_q.next_velocity <= vn_q;
          end
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == StDiv)
    else $error("accept did not start work");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> in_stall_o)
    else $error("ready while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> out_valid_q && $stable(out_q))
    else $error("stalled result changed");
endmodule

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cdf_pkg::*;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainCycles = 120;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_idx_i = RegSmoothTime;
  logic [30:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  cdf_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  cdf_out_t out_data_o;

  critically_damped_follower i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_stall_o, .in_data_i,
    .out_valid_o, .out_stall_i, .out_data_o
  );

  always #5 clk_i = ~clk_i;

  logic [63:0] smooth_cfg, speed_cfg, dt_cfg;
  longint velocity_q;
  cdf_out_t expected_steps[$];
  bit idle_on = 1'b1;
  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned sent = 0;
  int unsigned checked = 0;
  int unsigned cfg_writes = 0;
  int unsigned snaps = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic cdf_out_t spring_step(longint cur, longint goal);
    logic [63:0] st, omega, x, x2, x3, d, decay, lim;
    longint err, tgt, t7, vn, pos, om;
    cdf_out_t r;
    st = (smooth_cfg < 64'(MinSmoothRaw)) ? 64'(MinSmoothRaw) : smooth_cfg;
    omega = (64'd1 << 33) / st;
    x = (omega * dt_cfg) >> 16;
    x2 = (x * x) >> 16;
    if (x2 > 64'(PolyCap)) x2 = 64'(PolyCap);
    x3 = (x2 * x) >> 16;
    if (x3 > 64'(PolyCap)) x3 = 64'(PolyCap);
    d = 64'd65536 + x + ((64'(CoefSq) * x2) >> 16) + ((64'(CoefCu) * x3) >> 16);
    decay = (64'd1 << 32) / d;
    lim = (speed_cfg * st) >> 16;
    err = clip32(cur - goal);
    if (err > longint'(lim)) err = longint'(lim);
    if (err < -longint'(lim)) err = -longint'(lim);
    tgt = clip32(cur - err);
    om = longint'(omega);
    t7 = clip32(velocity_q + clip32((om * err) >>> 16));
    t7 = clip32((t7 * longint'(dt_cfg)) >>> 16);
    vn = clip32(velocity_q - clip32((om * t7) >>> 16));
    vn = clip32((vn * longint'(decay)) >>> 16);
    pos = clip32(err + t7);
    pos = clip32((pos * longint'(decay)) >>> 16);
    pos = clip32(tgt + pos);
    if (((goal - cur) > 0) == (pos > goal)) begin
      pos = goal;
      vn = 0;
      snaps++;
    end
    velocity_q = vn;
    r.next_pos = pos[31:0];
    r.next_velocity = vn[31:0];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] exp_v, logic [31:0] got_v);
    $display("ERROR t=%0t %s: expected %h got %h", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall_i <= idle_on && ($urandom_range(99) < 36);
  end

  always @(posedge clk_i) begin
    cdf_out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_steps.size() == 0) begin
        report_mismatch("unexpected result transaction", '0, out_data_o.next_pos);
      end else begin
        e = expected_steps.pop_front();
        checked++;
        if (out_data_o.next_pos !== e.next_pos)
          report_mismatch("next_pos", e.next_pos, out_data_o.next_pos);
        if (out_data_o.next_velocity !== e.next_velocity)
          report_mismatch("next_velocity", e.next_velocity, out_data_o.next_velocity);
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_step(logic [31:0] cur, logic [31:0] goal);
    cdf_in_t item;
    item.current_pos = cur;
    item.goal_pos = goal;
    in_data_i <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_steps.push_back(spring_step(longint'(item.current_pos),
                                         longint'(item.goal_pos)));
    sent++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 36) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    wait (expected_steps.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
    case (idx)
      RegSmoothTime: smooth_cfg = 64'(val);
      RegMaxSpeed:   speed_cfg = 64'(val);
      RegDeltaTime:  dt_cfg = 64'(val[15:0]);
      default: ;
    endcase
  endtask

  task automatic set_params(logic [30:0] st, logic [30:0] ms, logic [30:0] dt);
    write_reg(RegSmoothTime, st);
    write_reg(RegMaxSpeed, ms);
    write_reg(RegDeltaTime, dt);
  endtask

  function automatic logic [31:0] rand_pos();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(20000)) - 10000) <<< 12;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom_range(1) ? 32'h7FFF_FFFF - $urandom_range(5)
                                        : 32'h8000_0000 + $urandom_range(5);
    endcase
  endfunction

  task automatic test_extremes();
    send_step(32'h0, 32'h0);
    send_step(32'h7FFF_FFFF, 32'h8000_0000);
    send_step(32'h8000_0000, 32'h7FFF_FFFF);
    send_step(32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_step(32'h8000_0000, 32'h8000_0000);
    send_step(32'h0001_0000, 32'h0005_0000);
    send_step(32'h0005_0000, 32'h0005_0000);
    send_step(32'hFFFF_0000, 32'h0010_0000);
  endtask

  task automatic test_special_configs();
    set_params(31'd0, 31'h7FFF_FFFF, 31'd1092);
    send_step(32'h0000_0000, 32'h0100_0000);
    write_reg(RegSmoothTime, 31'd3);
    send_step(32'h0100_0000, 32'hFF00_0000);
    set_params(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'd0);
    send_step(32'h0000_0000, 32'h7FFF_FFFF);
    send_step(32'h8000_0000, 32'h0000_0000);
    set_params(31'd65536, 31'd0, 31'h7FFF_FFFF);
    send_step(32'h0010_0000, 32'h0000_0000);
    send_step(32'h0000_0000, 32'h0010_0000);
    set_params(31'd7, 31'd100, 31'd65535);
    send_step(32'h7FFF_FFFF, 32'h8000_0000);
    send_step(32'h0000_0000, 32'h0001_0000);
    write_reg(RegUnused, 31'h5555_5555);
    send_step(32'h0002_0000, 32'h0000_0000);
    set_params(31'd65536, 31'h7FFF_FFFF, 31'd1092);
  endtask

  task automatic test_random_follow(int unsigned count);
    logic [31:0] cur, goal;
    cdf_out_t last;
    int unsigned run;
    run = 0;
    cur = rand_pos();
    goal = rand_pos();
    repeat (count) begin
      if (run == 0 || $urandom_range(99) < 10) begin
        cur = rand_pos();
        goal = rand_pos();
        run = $urandom_range(40, 5);
      end else if ($urandom_range(99) < 8) begin
        goal = rand_pos();
      end
      send_step(cur, goal);
      last = expected_steps[$];
      cur = last.next_pos;
      run--;
    end
  endtask

  task automatic random_config();
    logic [30:0] st, ms, dt;
    case ($urandom_range(3))
      0: st = 31'($urandom_range(200000, 0));
      1: st = 31'($urandom_range(1 << 20, 1 << 14));
      default: st = 31'($urandom());
    endcase
    ms = $urandom_range(1) ? 31'($urandom()) : 31'($urandom_range(1 << 22));
    dt = $urandom_range(1) ? 31'($urandom_range(4000, 1)) : 31'($urandom());
    set_params(st, ms, dt);
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      idle_on = (p != 3);
      random_config();
      test_random_follow(125);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    smooth_cfg = 64'd65536;
    speed_cfg = 64'h7FFF_FFFF;
    dt_cfg = 64'd1092;
    velocity_q = 0;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_extremes();
    test_special_configs();
    test_random_phases();
    wait (expected_steps.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d step transactions, %0d checked, %0d goal snaps, %0d register writes",
             sent, checked, snaps, cfg_writes);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches", errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
